[hw/rtl/sefp_pkg.sv]
// Shared types, codes and a byte helper for the STX/ETX frame parser.
`timescale 1ns / 1ps
`default_nettype none

package sefp_pkg;

	localparam logic [7:0] CH_STX = 8'h02;
	localparam logic [7:0] CH_ETX = 8'h03;
	localparam logic [7:0] CH_UA  = 8'h41;
	localparam logic [7:0] CH_UZ  = 8'h5A;
	localparam logic [7:0] CH_LA  = 8'h61;
	localparam logic [7:0] CH_LZ  = 8'h7A;
	localparam logic [7:0] CH_D0  = 8'h30;
	localparam logic [7:0] CH_D9  = 8'h39;
	localparam logic [7:0] CH_SP  = 8'h20;
	localparam logic [7:0] CH_DOT = 8'h2E;
	localparam logic [7:0] CH_DSH = 8'h2D;
	localparam logic [7:0] CH_CR  = 8'h0D;
	localparam logic [7:0] CH_LF  = 8'h0A;

	localparam logic [1:0] KIND_ASCII = 2'd0;
	localparam logic [1:0] KIND_HDR   = 2'd1;
	localparam logic [1:0] KIND_DATA  = 2'd2;

	typedef enum logic [3:0] {
		OP_NONE,
		OP_ID,
		OP_LEN,
		OP_DATA,
		OP_CRC,
		OP_ETX,
		OP_ASCII,
		OP_HDR,
		OP_EMIT
	} sefp_op_t;

	typedef struct packed {
		logic rx_stx;
		logic rx_etx;
		logic rx_ascii;
		logic rx_zero;
		logic len_zero;
		logic too_long;
		logic data_done;
		logic crc_done;
		logic emit_last;
		logic slot_free;
	} sefp_stat_t;

	function automatic logic is_ascii(input logic [7:0] b);
		return (b >= CH_UA && b <= CH_UZ) || (b >= CH_LA && b <= CH_LZ) ||
			(b >= CH_D0 && b <= CH_D9) || b == CH_SP || b == CH_DOT ||
			b == CH_DSH || b == CH_CR || b == CH_LF;
	endfunction

endpackage

`default_nettype wire

[hw/rtl/sefp_ctrl.sv]
// Parser controller: frame phase sequencing and result release.
`timescale 1ns / 1ps
`default_nettype none

module sefp_ctrl
	import sefp_pkg::*;
(
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       rx_valid,
	output logic            rx_ready,
	input  wire sefp_stat_t stat,
	output sefp_op_t        op
);

	typedef enum logic [2:0] {
		S_START,
		S_ID,
		S_LEN,
		S_DATA,
		S_CRC,
		S_ETX,
		S_HDR,
		S_EMIT
	} state_t;

	state_t state_q;
	state_t state_d;
	logic   acc;

	always_comb begin
		case (state_q)
			S_ID, S_LEN, S_DATA, S_CRC: rx_ready = 1'b1;
			S_START, S_ETX:             rx_ready = stat.slot_free;
			default:                    rx_ready = 1'b0;
		endcase
	end

	assign acc = rx_valid && rx_ready;

	always_comb begin
		state_d = state_q;
		op      = OP_NONE;
		case (state_q)
			S_START: begin
				if (acc) begin
					if (stat.rx_stx) begin
						state_d = S_ID;
					end else if (stat.rx_ascii) begin
						op = OP_ASCII;
					end
				end
			end
			S_ID: begin
				if (acc) begin
					op      = OP_ID;
					state_d = S_LEN;
				end
			end
			S_LEN: begin
				if (acc) begin
					op      = OP_LEN;
					state_d = stat.rx_zero ? S_CRC : S_DATA;
				end
			end
			S_DATA: begin
				if (acc) begin
					op = OP_DATA;
					if (stat.data_done) begin
						state_d = S_CRC;
					end
				end
			end
			S_CRC: begin
				if (acc) begin
					op = OP_CRC;
					if (stat.crc_done) begin
						state_d = S_ETX;
					end
				end
			end
			S_ETX: begin
				if (acc) begin
					op      = OP_ETX;
					state_d = (stat.rx_etx && !stat.too_long) ? S_HDR : S_START;
				end
			end
			S_HDR: begin
				if (stat.slot_free) begin
					op      = OP_HDR;
					state_d = stat.len_zero ? S_START : S_EMIT;
				end
			end
			S_EMIT: begin
				if (stat.slot_free) begin
					op = OP_EMIT;
					if (stat.emit_last) begin
						state_d = S_START;
					end
				end
			end
			default: begin
				state_d = S_START;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_START;
		end else begin
			state_q <= state_d;
		end
	end

endmodule

`default_nettype wire

[hw/rtl/sefp_dp.sv]
// Parser datapath: held header fields, payload memory and output register.
`timescale 1ns / 1ps
`default_nettype none

module sefp_dp
	import sefp_pkg::*;
#(
	parameter int MAX_PAYLOAD = 32
) (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic [7:0] rx_byte,
	input  wire sefp_op_t   op,
	output sefp_stat_t      stat,
	input  wire logic       out_ready,
	output logic            out_valid,
	output logic [1:0]      out_kind,
	output logic [39:0]     out_data,
	output logic            out_last
);

	localparam int         AW      = (MAX_PAYLOAD > 1) ? $clog2(MAX_PAYLOAD) : 1;
	localparam logic [7:0] MAX_LEN = 8'(MAX_PAYLOAD);

	logic [7:0]  mem [MAX_PAYLOAD];
	logic [7:0]  rd_q;
	logic [7:0]  id_q;
	logic [7:0]  len_q;
	logic [15:0] crc_q;
	logic [7:0]  count_q;
	logic        too_long_q;
	logic        out_valid_q;
	logic [1:0]  kind_q;
	logic [7:0]  byte_q;
	logic [7:0]  oid_q;
	logic [7:0]  olen_q;
	logic [15:0] ocrc_q;
	logic        last_q;
	logic [7:0]  count_nxt;
	logic        slot_free;
	logic        emit_last;
	logic        load;

	assign count_nxt = count_q + 8'd1;
	assign slot_free = !out_valid_q || out_ready;
	assign emit_last = (count_nxt == len_q);
	assign load      = (op == OP_ASCII) || (op == OP_HDR) || (op == OP_EMIT);

	always_comb begin
		stat.rx_stx    = (rx_byte == CH_STX);
		stat.rx_etx    = (rx_byte == CH_ETX);
		stat.rx_ascii  = is_ascii(rx_byte);
		stat.rx_zero   = (rx_byte == 8'd0);
		stat.len_zero  = (len_q == 8'd0);
		stat.too_long  = too_long_q;
		stat.data_done = (count_nxt == len_q);
		stat.crc_done  = (count_q != 8'd0);
		stat.emit_last = emit_last;
		stat.slot_free = slot_free;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			id_q        <= '0;
			len_q       <= '0;
			crc_q       <= '0;
			count_q     <= '0;
			too_long_q  <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			case (op)
				OP_ID: begin
					id_q <= rx_byte;
				end
				OP_LEN: begin
					len_q      <= rx_byte;
					too_long_q <= (rx_byte > MAX_LEN);
					count_q    <= '0;
				end
				OP_DATA: begin
					count_q <= (count_nxt == len_q) ? 8'd0 : count_nxt;
				end
				OP_CRC: begin
					if (count_q == 8'd0) begin
						crc_q[15:8] <= rx_byte;
						count_q     <= 8'd1;
					end else begin
						crc_q[7:0] <= rx_byte;
						count_q    <= '0;
					end
				end
				OP_ETX: begin
					too_long_q <= 1'b0;
				end
				OP_EMIT: begin
					count_q <= emit_last ? 8'd0 : count_nxt;
				end
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (op == OP_DATA && !too_long_q) begin
			mem[count_q[AW-1:0]] <= rx_byte;
		end
		if (op == OP_HDR) begin
			rd_q <= mem['0];
		end else if (op == OP_EMIT && !emit_last) begin
			rd_q <= mem[count_nxt[AW-1:0]];
		end
	end

	always_ff @(posedge clk) begin
		case (op)
			OP_ASCII: begin
				kind_q <= KIND_ASCII;
				byte_q <= rx_byte;
				oid_q  <= '0;
				olen_q <= '0;
				ocrc_q <= '0;
				last_q <= 1'b1;
			end
			OP_HDR: begin
				kind_q <= KIND_HDR;
				byte_q <= '0;
				oid_q  <= id_q;
				olen_q <= len_q;
				ocrc_q <= crc_q;
				last_q <= (len_q == 8'd0);
			end
			OP_EMIT: begin
				kind_q <= KIND_DATA;
				byte_q <= rd_q;
				oid_q  <= id_q;
				olen_q <= len_q;
				ocrc_q <= crc_q;
				last_q <= emit_last;
			end
			default: begin
			end
		endcase
	end

	assign out_valid = out_valid_q;
	assign out_kind  = kind_q;
	assign out_data  = {ocrc_q[7:0], ocrc_q[15:8], olen_q, oid_q, byte_q};
	assign out_last  = last_q;

endmodule

`default_nettype wire

[hw/rtl/stx_etx_frame_parser.sv]
// Top level of the STX/ETX frame parser.
//
//  channel  | direction | tdata                                         | tuser | tlast
//  s_axis   | in        | [7:0] rx_byte                                 | -     | -
//  m_axis   | out       | byte_value, packet_id, packet_length,         | kind  | last
//           |           | crc_first, crc_second (8 bits each, low up)   |       |
//
// A byte is taken while s_axis_tready is high; an ascii byte gives its result in the next cycle.
// A good frame releases its header and then one data item per cycle while the output
// is not stalled, read through the single read port of the payload memory.
// Reset returns the parser to waiting for a start byte.
// Bytes that may produce a result (wait for start, ETX) wait while an item is held unread.
`timescale 1ns / 1ps
`default_nettype none

module stx_etx_frame_parser
	import sefp_pkg::*;
#(
	parameter int MAX_PAYLOAD = 32
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_axis_tvalid,
	output logic             s_axis_tready,
	input  wire logic [7:0]  s_axis_tdata,   // [7:0] rx_byte
	output logic             m_axis_tvalid,
	input  wire logic        m_axis_tready,
	output logic [39:0]      m_axis_tdata,   // byte_value, packet_id, packet_length, crc_first, crc_second
	output logic [1:0]       m_axis_tuser,   // [1:0] kind
	output logic             m_axis_tlast    // last
);

	sefp_stat_t stat;
	sefp_op_t   op;

	sefp_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.rx_valid (s_axis_tvalid),
		.rx_ready (s_axis_tready),
		.stat     (stat),
		.op       (op)
	);

	sefp_dp #(
		.MAX_PAYLOAD (MAX_PAYLOAD)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.rx_byte   (s_axis_tdata),
		.op        (op),
		.stat      (stat),
		.out_ready (m_axis_tready),
		.out_valid (m_axis_tvalid),
		.out_kind  (m_axis_tuser),
		.out_data  (m_axis_tdata),
		.out_last  (m_axis_tlast)
	);

endmodule

`default_nettype wire

[hw/rtl/sefp_checker.sv]
// Port-level checks for the STX/ETX frame parser, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none

module sefp_checker
	import sefp_pkg::*;
(
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        s_axis_tvalid,
	input wire logic        s_axis_tready,
	input wire logic [7:0]  s_axis_tdata,
	input wire logic        m_axis_tvalid,
	input wire logic        m_axis_tready,
	input wire logic [39:0] m_axis_tdata,
	input wire logic [1:0]  m_axis_tuser,
	input wire logic        m_axis_tlast
);

	a_in_hold: assert property (@(posedge clk) disable iff (!arst_n)
		s_axis_tvalid && !s_axis_tready |=> s_axis_tvalid && $stable(s_axis_tdata))
		else $error("stalled input item changed");

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata) &&
		$stable(m_axis_tuser) && $stable(m_axis_tlast))
		else $error("stalled output item changed");

	a_ascii: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tuser == KIND_ASCII |->
		m_axis_tlast && m_axis_tdata[39:8] == 32'd0)
		else $error("ascii item not alone or carries packet fields");

	a_hdr: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tuser == KIND_HDR |->
		m_axis_tdata[7:0] == 8'd0 && m_axis_tlast == (m_axis_tdata[23:16] == 8'd0))
		else $error("header last flag does not match length");

	a_follow: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tready && !m_axis_tlast &&
		(m_axis_tuser == KIND_HDR || m_axis_tuser == KIND_DATA) |=>
		!m_axis_tvalid || m_axis_tuser == KIND_DATA)
		else $error("packet run interrupted");

endmodule

bind stx_etx_frame_parser sefp_checker u_sefp_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.s_axis_tvalid (s_axis_tvalid),
	.s_axis_tready (s_axis_tready),
	.s_axis_tdata  (s_axis_tdata),
	.m_axis_tvalid (m_axis_tvalid),
	.m_axis_tready (m_axis_tready),
	.m_axis_tdata  (m_axis_tdata),
	.m_axis_tuser  (m_axis_tuser),
	.m_axis_tlast  (m_axis_tlast)
);

`default_nettype wire
